FILE: hw/rtl/bdq_pkg.sv
// shared types and constants for the bounded deque with remove
package bdq_pkg;

  // list size and derived widths
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  // action codes
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT   = 3'd0,
    ACT_PUSH_BACK    = 3'd1,
    ACT_POP_FRONT    = 3'd2,
    ACT_POP_BACK     = 3'd3,
    ACT_REMOVE_FIRST = 3'd4,
    ACT_REMOVE_ALL   = 3'd5,
    ACT_EXISTS       = 3'd6,
    ACT_CLEAR        = 3'd7
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_REPORT = 3'b100
  } state_e;

  // input item
  typedef struct packed {
    action_e                   action;
    logic signed [VAL_W-1:0]   value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [VAL_W-1:0]   front_value;
    logic signed [VAL_W-1:0]   back_value;
    logic        [CNT_W-1:0]   entry_count;
    logic                      found;
    status_e                   status;
  } out_item_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                      shift_right;
    logic                      compact;
    logic                      load_tail;
    logic signed [VAL_W-1:0]   value;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/bdq_cell.sv
// one list position: holds a value, compares it and moves it to a neighbor
module bdq_cell (
  input  logic                                clk_i,
  input  bdq_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [bdq_pkg::VAL_W-1:0]    left_val_i,
  input  logic signed [bdq_pkg::VAL_W-1:0]    right_val_i,
  input  logic                                occ_i,
  input  logic                                tail_i,
  input  logic                                last_i,
  input  logic                                chain_i,
  output logic                                chain_o,
  input  logic signed [bdq_pkg::VAL_W-1:0]    back_i,
  output logic signed [bdq_pkg::VAL_W-1:0]    back_o,
  output logic signed [bdq_pkg::VAL_W-1:0]    val_o
);

  logic signed [bdq_pkg::VAL_W-1:0] val_q;
  logic signed [bdq_pkg::VAL_W-1:0] val_d;
  logic                             match;

  // match against the broadcast value, only for occupied positions
  assign match   = occ_i && (val_q == ctrl_i.value);
  // once a match (or pop seed) is seen, that cell and every later cell pull from the right
  assign chain_o = chain_i || match;

  // pass the back element down the chain
  assign back_o  = last_i ? val_q : back_i;
  assign val_o   = val_q;

  // next value selection
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift_right) begin
      val_d = left_val_i;
    end else if (ctrl_i.compact && chain_o) begin
      val_d = right_val_i;
    end else if (ctrl_i.load_tail && tail_i) begin
      val_d = ctrl_i.value;
    end
  end

  // value storage
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: hw/rtl/bounded_deque_with_remove_unit.sv
// top level: ordered list of signed values held in a row of cells
//
// Bounded double-ended list with search and delete, up to LIST_DEPTH entries.
// Input channel in_valid_i / in_ready_o carries one item: an action (push
// front/back, pop front/back, remove first match, remove all matches, exists,
// clear) and a 32-bit value. Output channel out_valid_o / out_ready_i carries
// one result per item: front and back after the action (0 when empty), the
// entry count, a found flag and a status code.
// An accepted item moves to the report step, where its result is registered
// in the output register. Remove all first runs the sweep step, which drops
// the matches one at a time until none is left. The cells update in the accept
// cycle (in the sweep step for remove all); the result is formed from the
// updated cells in the report cycle. Items are taken one at a time; in_ready_o
// is high only when the sequencer is idle. When the receiver stalls the result
// waits in the output register; one more item is still taken, and the
// sequencer then holds in its report step.
// Reset clears the count, the sequencer and the output valid; the cell
// values are not reset and are never read before being written.
module bounded_deque_with_remove_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bdq_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bdq_pkg::out_item_t   out_item_o
);

  localparam int unsigned N = bdq_pkg::LIST_DEPTH;

  bdq_pkg::state_e                     state_q, state_d;
  logic [bdq_pkg::CNT_W-1:0]           count_q, count_d;
  logic                                found_q, found_d;
  bdq_pkg::status_e                    status_q, status_d;
  logic signed [bdq_pkg::VAL_W-1:0]    value_q, value_d;
  logic                                out_valid_q, out_valid_d;
  bdq_pkg::out_item_t                  out_item_q, out_item_d;

  bdq_pkg::cell_ctrl_t                 ctrl;
  logic                                accept;
  logic                                full;
  logic                                empty;
  logic                                any_match;
  logic                                out_free;

  logic signed [bdq_pkg::VAL_W-1:0]    cell_val   [N];
  logic                                match_chain[N+1];
  logic signed [bdq_pkg::VAL_W-1:0]    back_chain [N+1];

  // handshake and list status
  assign in_ready_o = (state_q == bdq_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == bdq_pkg::CNT_W'(N));
  assign empty      = (count_q == '0);
  assign out_free   = !out_valid_q || out_ready_i;
  assign any_match  = match_chain[N];

  // cell control broadcast
  always_comb begin
    ctrl.value       = (state_q == bdq_pkg::S_SWEEP) ? value_q : in_item_i.value;
    ctrl.shift_right = accept && (in_item_i.action == bdq_pkg::ACT_PUSH_FRONT) && !full;
    ctrl.load_tail   = accept && (in_item_i.action == bdq_pkg::ACT_PUSH_BACK) && !full;
    ctrl.compact     = (state_q == bdq_pkg::S_SWEEP)
                    || (accept && (in_item_i.action == bdq_pkg::ACT_REMOVE_FIRST))
                    || (accept && (in_item_i.action == bdq_pkg::ACT_POP_FRONT) && !empty);
  end

  // chain seeds: pop front shifts the whole row left
  assign match_chain[0] = accept && (in_item_i.action == bdq_pkg::ACT_POP_FRONT);
  assign back_chain[0]  = '0;

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [bdq_pkg::VAL_W-1:0] left_val;
    logic signed [bdq_pkg::VAL_W-1:0] right_val;
    logic                             occ;
    logic                             tail;
    logic                             last;

    if (i == 0) begin : g_first
      assign left_val = ctrl.value;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == N - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    assign occ  = (count_q > bdq_pkg::CNT_W'(i));
    assign tail = (count_q == bdq_pkg::CNT_W'(i));
    assign last = (count_q == bdq_pkg::CNT_W'(i + 1));

    bdq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .occ_i       (occ),
      .tail_i      (tail),
      .last_i      (last),
      .chain_i     (match_chain[i]),
      .chain_o     (match_chain[i+1]),
      .back_i      (back_chain[i]),
      .back_o      (back_chain[i+1]),
      .val_o       (cell_val[i])
    );
  end

  // sequencer, count and result flags
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    found_d  = found_q;
    status_d = status_q;
    value_d  = value_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          found_d  = 1'b0;
          status_d = bdq_pkg::ST_OK;
          value_d  = in_item_i.value;
          state_d  = bdq_pkg::S_REPORT;
          case (in_item_i.action)
            bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
              if (full) begin
                status_d = bdq_pkg::ST_FULL;
              end else begin
                count_d = count_q + bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::ACT_POP_FRONT, bdq_pkg::ACT_POP_BACK: begin
              if (empty) begin
                status_d = bdq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::ACT_REMOVE_FIRST: begin
              if (any_match) begin
                found_d = 1'b1;
                count_d = count_q - bdq_pkg::CNT_W'(1);
              end else begin
                status_d = bdq_pkg::ST_NOTFOUND;
              end
            end
            bdq_pkg::ACT_REMOVE_ALL: begin
              state_d = bdq_pkg::S_SWEEP;
            end
            bdq_pkg::ACT_EXISTS: begin
              found_d = any_match;
            end
            bdq_pkg::ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
              count_d = count_q;
            end
          endcase
        end
      end
      bdq_pkg::S_SWEEP: begin
        // drop one match per cycle until none is left
        if (any_match) begin
          found_d = 1'b1;
          count_d = count_q - bdq_pkg::CNT_W'(1);
        end else begin
          status_d = found_q ? bdq_pkg::ST_OK : bdq_pkg::ST_NOTFOUND;
          state_d  = bdq_pkg::S_REPORT;
        end
      end
      bdq_pkg::S_REPORT: begin
        if (out_free) begin
          state_d = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if ((state_q == bdq_pkg::S_REPORT) && out_free) begin
      out_valid_d            = 1'b1;
      out_item_d.front_value = empty ? '0 : cell_val[0];
      out_item_d.back_value  = back_chain[N];
      out_item_d.entry_count = count_q;
      out_item_d.found       = found_q;
      out_item_d.status      = status_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    found_q    <= found_d;
    status_q   <= status_d;
    value_q    <= value_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // count never goes past the list size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bdq_pkg::CNT_W'(N))
    else $error("entry count above list depth");

  // a push on a full list leaves it full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (in_item_i.action == bdq_pkg::ACT_PUSH_FRONT ||
                        in_item_i.action == bdq_pkg::ACT_PUSH_BACK))
    |=> (count_q == bdq_pkg::CNT_W'(N)))
    else $error("dropped push changed the count");

  // clear empties the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_item_i.action == bdq_pkg::ACT_CLEAR)) |=> empty)
    else $error("clear left entries behind");

  // sweep with no match left goes to report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == bdq_pkg::S_SWEEP) && !any_match) |=> (state_q == bdq_pkg::S_REPORT))
    else $error("sweep did not finish");

  // report step with a free slot registers a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == bdq_pkg::S_REPORT) && out_free) |=> out_valid_q)
    else $error("result not registered");

endmodule
